[rtl/gateway_info_table_core_assert.svh]
// Assertion macros for the gateway info table RTL.
`ifndef GATEWAY_INFO_TABLE_CORE_ASSERT_SVH
`define GATEWAY_INFO_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while the design is out of reset.
`define GIT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gateway info table assertion failed");
// Checked on every clock edge, reset included.
`define GIT_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("gateway info table assertion failed");
`else
`define GIT_ASSERT(name, clk, rst_n, prop)
`define GIT_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[rtl/gwit_pkg.sv]
// Shared constants and types of the gateway info table.
package gwit_pkg;

    localparam int TABLE_DEPTH     = 8;
    localparam int ADDRESS_BITS    = 48;
    localparam int FIELD_ADDR_BITS = 48;
    localparam int STORE_BITS      = (ADDRESS_BITS < FIELD_ADDR_BITS) ?
                                     ADDRESS_BITS : FIELD_ADDR_BITS;
    localparam int IDX_W           = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic signed [15:0] STRENGTH_MIN = 16'sh8000;
    localparam logic signed [15:0] STRENGTH_MAX = 16'sh7FFF;

    localparam logic [1:0] OP_DIRECT = 2'd0;
    localparam logic [1:0] OP_RELAY  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Step commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic find;
        logic write;
        logic search;
    } t_cmd;

endpackage

[rtl/gwit_ctrl.sv]
// Sequencer of the gateway info table: load, find slot, write, search.
`include "gateway_info_table_core_assert.svh"

module gwit_ctrl
    import gwit_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd,
    output logic o_valid
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_FIND   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_SEARCH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_FIND;
                end
            end
            ST_FIND:   n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_SEARCH;
            ST_SEARCH: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_SEARCH);
        end
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_cmd.load   = (r_state == ST_IDLE) && start;
    assign o_cmd.find   = (r_state == ST_FIND);
    assign o_cmd.write  = (r_state == ST_WRITE);
    assign o_cmd.search = (r_state == ST_SEARCH);
    assign o_valid      = r_valid;

    `GIT_ASSERT(a_accept_to_find, i_clk, i_rst_n, (start && !busy) |=> (r_state == ST_FIND))
    `GIT_ASSERT(a_result_latency, i_clk, i_rst_n, (start && !busy) |-> ##4 o_valid)
    `GIT_ASSERT(a_result_single, i_clk, i_rst_n, o_valid |=> !o_valid)
    `GIT_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> (!busy && !o_valid))

endmodule

[rtl/gwit_datapath.sv]
// Table storage, slot selection, strongest-entry search and result registers.
module gwit_datapath
    import gwit_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    input  logic [1:0]                  i_operation,
    input  logic [FIELD_ADDR_BITS-1:0]  i_source_address,
    input  logic [FIELD_ADDR_BITS-1:0]  i_reported_address,
    input  logic [7:0]                  i_gateway_id,
    input  logic signed [15:0]          i_signal_strength,
    output logic                        o_accepted,
    output logic                        o_best_valid,
    output logic [FIELD_ADDR_BITS-1:0]  o_best_address,
    output logic [7:0]                  o_best_id,
    output logic signed [15:0]          o_best_strength
);

    logic [STORE_BITS-1:0]  r_entry_addr [TABLE_DEPTH];
    logic [7:0]             r_entry_id   [TABLE_DEPTH];
    logic signed [15:0]     r_entry_str  [TABLE_DEPTH];
    logic                   r_seen;

    logic [1:0]             r_op;
    logic [STORE_BITS-1:0]  r_src;
    logic [STORE_BITS-1:0]  r_rep;
    logic [7:0]             r_id;
    logic signed [15:0]     r_str;

    logic [IDX_W-1:0]       r_slot, n_slot;
    logic                   r_store, n_store;

    logic                   r_accepted;
    logic                   r_best_valid;
    logic [STORE_BITS-1:0]  r_best_addr;
    logic [7:0]             r_best_id;
    logic signed [15:0]     r_best_str;

    logic                   match_hit, empty_hit, best_hit;
    logic [IDX_W-1:0]       match_idx, empty_idx, min_idx, best_idx;
    logic signed [15:0]     lowest, best_s;
    logic                   is_relay_ok;

    // Slot choice: same address first, then first empty entry, then the weakest.
    always_comb begin
        match_hit = 1'b0;
        empty_hit = 1'b0;
        match_idx = '0;
        empty_idx = '0;
        min_idx   = '0;
        lowest    = STRENGTH_MAX;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!match_hit && (r_entry_addr[i] == r_src)) begin
                match_hit = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!empty_hit && (r_entry_id[i] == 8'd0)) begin
                empty_hit = 1'b1;
                empty_idx = IDX_W'(i);
            end
            if (r_entry_str[i] < lowest) begin
                lowest  = r_entry_str[i];
                min_idx = IDX_W'(i);
            end
        end
        if (match_hit) begin
            n_slot = match_idx;
        end else if (empty_hit) begin
            n_slot = empty_idx;
        end else begin
            n_slot = min_idx;
        end
        is_relay_ok = (r_op == OP_RELAY) && (r_id != 8'd0) && (r_src == r_rep);
        n_store     = (r_op == OP_DIRECT) || is_relay_ok;
    end

    // Strongest occupied entry; a strictly greater strength is needed, so the
    // first entry wins on ties and the most negative strength never qualifies.
    always_comb begin
        best_hit = 1'b0;
        best_idx = '0;
        best_s   = STRENGTH_MIN;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if ((r_entry_id[i] != 8'd0) && (r_entry_str[i] > best_s)) begin
                best_hit = 1'b1;
                best_s   = r_entry_str[i];
                best_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_src <= i_source_address[STORE_BITS-1:0];
            r_rep <= i_reported_address[STORE_BITS-1:0];
            r_id  <= i_gateway_id;
            r_str <= i_signal_strength;
        end
        if (i_cmd.find) begin
            r_slot  <= n_slot;
            r_store <= n_store;
        end
        if (i_cmd.search) begin
            r_accepted <= r_store;
            if (r_seen && best_hit) begin
                r_best_valid <= 1'b1;
                r_best_addr  <= r_entry_addr[best_idx];
                r_best_id    <= r_entry_id[best_idx];
                r_best_str   <= r_entry_str[best_idx];
            end else begin
                r_best_valid <= 1'b0;
                r_best_addr  <= '0;
                r_best_id    <= '0;
                r_best_str   <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_entry_addr[i] <= '0;
                r_entry_id[i]   <= '0;
                r_entry_str[i]  <= '0;
            end
            r_seen <= 1'b0;
        end else if (i_cmd.write) begin
            if (r_op == OP_CLEAR) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    r_entry_addr[i] <= '0;
                    r_entry_id[i]   <= '0;
                    r_entry_str[i]  <= '0;
                end
                r_seen <= 1'b0;
            end else begin
                if (r_store) begin
                    r_entry_addr[r_slot] <= r_src;
                    r_entry_id[r_slot]   <= r_id;
                    r_entry_str[r_slot]  <= r_str;
                end
                // A relayed report with a nonzero id counts as seen even if dropped.
                if ((r_op == OP_DIRECT) || ((r_op == OP_RELAY) && (r_id != 8'd0))) begin
                    r_seen <= 1'b1;
                end
            end
        end
    end

    assign o_accepted      = r_accepted;
    assign o_best_valid    = r_best_valid;
    assign o_best_address  = FIELD_ADDR_BITS'(r_best_addr);
    assign o_best_id       = r_best_id;
    assign o_best_strength = r_best_str;

endmodule

[rtl/gateway_info_table_core.sv]
// Top level of the gateway info table: sequencer plus datapath.
//
// Keeps a table of eight discovered gateways. A transaction is taken when start
// is high and busy is low; busy then stays high through the three sequencer steps
// (find, write, search) while the block picks the target slot (same address,
// first empty entry, or weakest signal), writes the table, and searches for the
// strongest occupied entry. The result is registered at the end of the search
// step and appears on the o_ ports for exactly one cycle with o_valid high; it
// cannot be held off by the receiver. A new transaction may be started in the
// cycle that o_valid is high, but not while busy is high.
// Reset empties the table at once; no clearing pass is needed.
module gateway_info_table_core
    import gwit_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_operation,
    input  logic [FIELD_ADDR_BITS-1:0]  i_source_address,
    input  logic [FIELD_ADDR_BITS-1:0]  i_reported_address,
    input  logic [7:0]                  i_gateway_id,
    input  logic signed [15:0]          i_signal_strength,
    output logic                        o_valid,
    output logic                        o_accepted,
    output logic                        o_best_valid,
    output logic [FIELD_ADDR_BITS-1:0]  o_best_address,
    output logic [7:0]                  o_best_id,
    output logic signed [15:0]          o_best_strength
);

    t_cmd cmd;

    gwit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_valid (o_valid)
    );

    gwit_datapath u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_operation        (i_operation),
        .i_source_address   (i_source_address),
        .i_reported_address (i_reported_address),
        .i_gateway_id       (i_gateway_id),
        .i_signal_strength  (i_signal_strength),
        .o_accepted         (o_accepted),
        .o_best_valid       (o_best_valid),
        .o_best_address     (o_best_address),
        .o_best_id          (o_best_id),
        .o_best_strength    (o_best_strength)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the gateway info table core.
`timescale 1ns / 100ps

module tb;
    import gwit_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POOL_SIZE = 12;
    localparam logic [FIELD_ADDR_BITS-1:0] ADDR_KEEP =
        {FIELD_ADDR_BITS{1'b1}} >> (FIELD_ADDR_BITS - STORE_BITS);
    localparam logic [FIELD_ADDR_BITS-1:0] ADDR_ONES = {FIELD_ADDR_BITS{1'b1}};

    typedef struct {
        logic                       accepted;
        logic                       best_valid;
        logic [FIELD_ADDR_BITS-1:0] best_address;
        logic [7:0]                 best_id;
        logic signed [15:0]         best_strength;
    } t_gw_answer;

    // Mirrors the gateway table and keeps the answers still owed by the block.
    class gateway_table_scoreboard;
        logic [FIELD_ADDR_BITS-1:0] gw_addr [TABLE_DEPTH];
        logic [7:0]                 gw_id [TABLE_DEPTH];
        logic signed [15:0]         gw_rssi [TABLE_DEPTH];
        logic                       report_seen;
        t_gw_answer                 due_answers [$];
        int                         mismatches;

        function new();
            wipe_table();
            mismatches = 0;
        endfunction

        function void wipe_table();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                gw_addr[i] = '0;
                gw_id[i]   = '0;
                gw_rssi[i] = '0;
            end
            report_seen = 1'b0;
        endfunction

        function void place_report(logic [FIELD_ADDR_BITS-1:0] addr, logic [7:0] id,
                                   logic signed [15:0] rssi);
            int slot;
            logic signed [15:0] lowest;
            slot = -1;
            for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
                if (gw_addr[i] == addr) slot = i;
            for (int i = 0; i < TABLE_DEPTH && slot < 0; i++)
                if (gw_id[i] == 8'd0) slot = i;
            if (slot < 0) begin
                // Weakest entry: strict-less search from the top of the range.
                lowest = STRENGTH_MAX;
                slot = 0;
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (gw_rssi[i] < lowest) begin
                        lowest = gw_rssi[i];
                        slot = i;
                    end
                end
            end
            gw_addr[slot] = addr;
            gw_id[slot]   = id;
            gw_rssi[slot] = rssi;
        endfunction

        function void note_request(logic [1:0] op, logic [FIELD_ADDR_BITS-1:0] src,
                                   logic [FIELD_ADDR_BITS-1:0] rep, logic [7:0] id,
                                   logic signed [15:0] rssi);
            t_gw_answer ans;
            logic [FIELD_ADDR_BITS-1:0] src_key;
            logic [FIELD_ADDR_BITS-1:0] rep_key;
            int best;
            logic signed [15:0] best_rssi;
            ans = '{default: '0};
            src_key = src & ADDR_KEEP;
            rep_key = rep & ADDR_KEEP;
            case (op)
                OP_DIRECT: begin
                    place_report(src_key, id, rssi);
                    report_seen = 1'b1;
                    ans.accepted = 1'b1;
                end
                OP_RELAY: begin
                    if (id != 8'd0) begin
                        if (src_key == rep_key) begin
                            place_report(src_key, id, rssi);
                            ans.accepted = 1'b1;
                        end
                        report_seen = 1'b1;
                    end
                end
                OP_CLEAR: wipe_table();
                default: ;
            endcase
            best = -1;
            best_rssi = STRENGTH_MIN;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (gw_id[i] != 8'd0 && gw_rssi[i] > best_rssi) begin
                    best_rssi = gw_rssi[i];
                    best = i;
                end
            end
            if (report_seen && best >= 0) begin
                ans.best_valid    = 1'b1;
                ans.best_address  = gw_addr[best];
                ans.best_id       = gw_id[best];
                ans.best_strength = gw_rssi[best];
            end
            due_answers.push_back(ans);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_answer(t_gw_answer got);
            t_gw_answer want;
            if (due_answers.size() == 0) begin
                report_mismatch("result with no transaction outstanding");
            end else begin
                want = due_answers.pop_front();
                if (got.accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %b, want %b",
                                              got.accepted, want.accepted));
                if (got.best_valid !== want.best_valid)
                    report_mismatch($sformatf("best_valid %b, want %b",
                                              got.best_valid, want.best_valid));
                if (got.best_address !== want.best_address)
                    report_mismatch($sformatf("best_address %h, want %h",
                                              got.best_address, want.best_address));
                if (got.best_id !== want.best_id)
                    report_mismatch($sformatf("best_id %h, want %h",
                                              got.best_id, want.best_id));
                if (got.best_strength !== want.best_strength)
                    report_mismatch($sformatf("best_strength %0d, want %0d",
                                              got.best_strength, want.best_strength));
            end
        endtask

        function int pending();
            return due_answers.size();
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 i_operation;
    logic [FIELD_ADDR_BITS-1:0] i_source_address;
    logic [FIELD_ADDR_BITS-1:0] i_reported_address;
    logic [7:0]                 i_gateway_id;
    logic signed [15:0]         i_signal_strength;
    logic                       o_valid;
    logic                       o_accepted;
    logic                       o_best_valid;
    logic [FIELD_ADDR_BITS-1:0] o_best_address;
    logic [7:0]                 o_best_id;
    logic signed [15:0]         o_best_strength;

    gateway_table_scoreboard sb = new();
    logic [FIELD_ADDR_BITS-1:0] addr_pool [POOL_SIZE];
    logic no_idle;
    int cycle_count = 0;

    gateway_info_table_core DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_source_address   (i_source_address),
        .i_reported_address (i_reported_address),
        .i_gateway_id       (i_gateway_id),
        .i_signal_strength  (i_signal_strength),
        .o_valid            (o_valid),
        .o_accepted         (o_accepted),
        .o_best_valid       (o_best_valid),
        .o_best_address     (o_best_address),
        .o_best_id          (o_best_id),
        .o_best_strength    (o_best_strength)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Results cannot be stalled, so every strobe is checked on the edge that ends it.
    always @(posedge i_clk) begin
        t_gw_answer got;
        if (i_rst_n && o_valid) begin
            got.accepted      = o_accepted;
            got.best_valid    = o_best_valid;
            got.best_address  = o_best_address;
            got.best_id       = o_best_id;
            got.best_strength = o_best_strength;
            sb.check_answer(got);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction is taken.
    task send_request(logic [1:0] op, logic [FIELD_ADDR_BITS-1:0] src,
                      logic [FIELD_ADDR_BITS-1:0] rep, logic [7:0] id,
                      logic signed [15:0] rssi);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start              = 1'b1;
        i_operation        = op;
        i_source_address   = src;
        i_reported_address = rep;
        i_gateway_id       = id;
        i_signal_strength  = rssi;
        do @(posedge i_clk); while (busy);
        sb.note_request(op, src, rep, id, rssi);
        @(negedge i_clk);
    endtask

    function logic [FIELD_ADDR_BITS-1:0] rand_addr();
        return FIELD_ADDR_BITS'({$urandom(), $urandom()});
    endfunction

    function logic [FIELD_ADDR_BITS-1:0] pick_addr();
        if ($urandom_range(0, 99) < 85)
            return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return rand_addr();
    endfunction

    function logic signed [15:0] pick_rssi();
        case ($urandom_range(0, 7))
            0: return STRENGTH_MIN;
            1: return STRENGTH_MAX;
            2: return 16'($urandom_range(0, 3) * 10);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task run_directed();
        send_request(OP_DIRECT, '0, '0, 8'd0, 16'sd0);
        send_request(OP_RELAY, 48'h1111, 48'h1111, 8'd0, 16'sd100);
        send_request(OP_RELAY, 48'h2222, 48'h3333, 8'd5, 16'sd200);
        send_request(OP_RELAY, ADDR_ONES, ADDR_ONES, 8'd255, STRENGTH_MAX);
        send_request(OP_DIRECT, 48'h10, ADDR_ONES, 8'd1, STRENGTH_MIN);
        // The first two share a strength so the earlier entry must win the tie.
        for (int k = 0; k < 6; k++)
            send_request(OP_DIRECT, 48'h20 + k, '0, 8'(k + 2),
                         (k < 2) ? 16'sd500 : 16'(-100 * k));
        send_request(OP_DIRECT, 48'h30, '0, 8'd9, 16'sd300);
        send_request(OP_DIRECT, 48'h20, '0, 8'd0, 16'sd700);
        send_request(OP_DIRECT, 48'h31, '0, 8'd10, 16'sd600);
        send_request(OP_UNUSED, 48'h32, 48'h32, 8'd11, 16'sd900);
        send_request(OP_CLEAR, 48'h33, 48'h34, 8'd12, 16'sd1);
        send_request(OP_RELAY, 48'h40, 48'h41, 8'd7, 16'sd10);
        send_request(OP_DIRECT, 48'h50, '0, 8'd3, STRENGTH_MIN);
        send_request(OP_DIRECT, 48'h51, '0, 8'd4, STRENGTH_MAX);
        send_request(OP_DIRECT, 48'h52, '0, 8'd6, STRENGTH_MAX);
    endtask

    task run_random(int count);
        int sel;
        logic [1:0] op;
        logic [FIELD_ADDR_BITS-1:0] src;
        logic [FIELD_ADDR_BITS-1:0] rep;
        logic [7:0] id;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
            sel = $urandom_range(0, 99);
            src = pick_addr();
            rep = rand_addr();
            id  = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
            if (sel < 3) begin
                op = OP_CLEAR;
            end else if (sel < 5) begin
                op = OP_UNUSED;
            end else if (sel < 50) begin
                op = OP_DIRECT;
            end else begin
                op = OP_RELAY;
                sel = $urandom_range(0, 9);
                if (sel < 8) rep = src;
                else if (sel == 8) id = 8'd0;
            end
            send_request(op, src, rep, id, pick_rssi());
        end
    endtask

    initial begin
        start              = 1'b0;
        i_rst_n            = 1'b0;
        i_operation        = OP_DIRECT;
        i_source_address   = '0;
        i_reported_address = '0;
        i_gateway_id       = '0;
        i_signal_strength  = '0;
        no_idle            = 1'b0;
        addr_pool[0] = '0;
        addr_pool[1] = ADDR_ONES;
        for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        run_random(1300);
        start = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
